### rtl/vlmr_pkg.sv
// vlmr_pkg: shared widths, codes, state machine type and the command and status
// structs between the controller and the datapath of the message ring
// no dependencies
`timescale 1ns / 1ps

package vlmr_pkg;

   localparam int SIZE_W            = 11;
   localparam int LEN_W             = 7;
   localparam int BYTE_W            = 8;
   localparam int STAT_W            = 3;
   localparam int TYPE_W            = 2;
   localparam int CSR_IDX_W         = 1;
   localparam int DEF_STORE_BYTES   = 1024;
   localparam int DEF_MAX_MSG_BYTES = 64;
   localparam int HEADER_BYTES      = 4;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MSG     = 1'b1;

   typedef enum logic [TYPE_W-1:0] {
      REQ_SEND_BEGIN = 2'd0,
      REQ_SEND_DATA  = 2'd1,
      REQ_RECEIVE    = 2'd2,
      REQ_UNUSED     = 2'd3
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_BAD_LEN = 3'd1,
      ST_NO_ROOM = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_IGNORED = 3'd4,
      ST_BUSY    = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_HDR_RD,
      FSM_HDR_LD,
      FSM_BYTE_RD,
      FSM_BYTE_OUT
   } fsm_state_type;

   typedef struct packed {
      logic simple_load;
      logic rx_start;
      logic hdr_read;
      logic hdr_load;
      logic byte_read;
      logic byte_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rx_go;
      logic out_free;
      logic last_byte;
      logic zero_len;
   } dp_status_type;

endpackage

### rtl/vlmr_ctrl.sv
// vlmr_ctrl: state machine that sequences beat acceptance and the receive run
// depends on vlmr_pkg
`timescale 1ns / 1ps

module vlmr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  vlmr_pkg::dp_status_type dp_status,
   output vlmr_pkg::ctrl_cmd_type  cmd
);
   import vlmr_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          accept;

   assign req_ready = (state_ff == FSM_IDLE) && dp_status.out_free;
   assign accept    = req_valid && req_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept && dp_status.rx_go) state_in = FSM_HDR_RD;
         end
         FSM_HDR_RD: begin
            state_in = FSM_HDR_LD;
         end
         FSM_HDR_LD: begin
            state_in = dp_status.zero_len ? FSM_BYTE_OUT : FSM_BYTE_RD;
         end
         FSM_BYTE_RD: begin
            state_in = FSM_BYTE_OUT;
         end
         FSM_BYTE_OUT: begin
            if (dp_status.out_free) begin
               state_in = dp_status.last_byte ? FSM_IDLE : FSM_BYTE_RD;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd = '0;
      case (state_ff)
         FSM_IDLE: begin
            cmd.simple_load = accept && !dp_status.rx_go;
            cmd.rx_start    = accept && dp_status.rx_go;
         end
         FSM_HDR_RD:   cmd.hdr_read  = 1'b1;
         FSM_HDR_LD:   cmd.hdr_load  = 1'b1;
         FSM_BYTE_RD:  cmd.byte_read = 1'b1;
         FSM_BYTE_OUT: cmd.byte_emit = dp_status.out_free;
         default:      cmd = '0;
      endcase
   end

endmodule

### rtl/vlmr_datapath.sv
// vlmr_datapath: ring pointers, free count, byte store and result register
// depends on vlmr_pkg; driven by vlmr_ctrl commands
`timescale 1ns / 1ps

module vlmr_datapath #(
   parameter int STORE_BYTES   = vlmr_pkg::DEF_STORE_BYTES,
   parameter int MAX_MSG_BYTES = vlmr_pkg::DEF_MAX_MSG_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [vlmr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vlmr_pkg::SIZE_W-1:0]          csr_wdata,
   input  logic [vlmr_pkg::TYPE_W-1:0]          req_type,
   input  logic [vlmr_pkg::LEN_W-1:0]           req_msg_len,
   input  logic [vlmr_pkg::BYTE_W-1:0]          req_data_byte,
   input  vlmr_pkg::ctrl_cmd_type               cmd,
   output vlmr_pkg::dp_status_type              dp_status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vlmr_pkg::STAT_W-1:0]          rsp_status,
   output logic [vlmr_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic [vlmr_pkg::LEN_W-1:0]           rsp_out_len,
   output logic                                 rsp_last,
   output logic [vlmr_pkg::SIZE_W-1:0]          rsp_free_bytes,
   output logic [vlmr_pkg::LEN_W-1:0]           rsp_next_len
);
   import vlmr_pkg::*;

   localparam int PTR_W = $clog2(STORE_BYTES);
   localparam int AW    = ((PTR_W > SIZE_W) ? PTR_W : SIZE_W) + 1;
   localparam logic [AW-1:0] CAP        = AW'(STORE_BYTES) & ~AW'(3);
   localparam logic [AW-1:0] HDR        = AW'(HEADER_BYTES);
   localparam logic [AW-1:0] RESET_SIZE = (AW'(1024) > CAP) ? CAP : AW'(1024);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MSG_BYTES);

   // round up to a multiple of four
   function automatic logic [AW-1:0] round4(input logic [AW-1:0] x);
      round4 = (x + AW'(3)) & ~AW'(3);
   endfunction

   // ring state
   logic [AW-1:0]    size_ff, size_in, free_ff, free_in;
   logic [LEN_W-1:0] max_ff, max_in, rem_ff, rem_in, head_ff, head_in;
   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in, p_ff, p_in;
   logic             open_ff, open_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in, rxlen_ff, rxlen_in;

   // result register
   logic                rv_ff, rv_in, rlast_ff, rlast_in;
   logic [STAT_W-1:0]   rst_ff, rst_in;
   logic [BYTE_W-1:0]   rbyte_ff, rbyte_in;
   logic [LEN_W-1:0]    rlen_ff, rlen_in, rnext_ff, rnext_in;
   logic [SIZE_W-1:0]   rfree_ff, rfree_in;

   // byte store
   logic [BYTE_W-1:0] mem [STORE_BYTES];
   logic [BYTE_W-1:0] rdata_ff;
   logic              mem_we, rd_en;
   logic [PTR_W-1:0]  mem_waddr, rd_addr;
   logic [BYTE_W-1:0] mem_wdata;

   // helpers
   logic [AW-1:0]    r4_len, r4_head, csr_size, wp_x, rp_x, p_x, step_x, algn_x, p0_x, nrp_x;
   logic [AW-1:0]    free_add;
   logic [LEN_W-1:0] lim;
   logic             empty, out_free;
   status_type       st;

   assign out_free = !rv_ff || rsp_ready;
   assign empty    = (free_ff == size_ff);
   assign lim      = (max_ff < MAX_LEN) ? max_ff : MAX_LEN;
   assign r4_len   = round4(AW'(req_msg_len));
   assign r4_head  = round4(AW'(head_ff));
   assign wp_x     = AW'(wp_ff);
   assign rp_x     = AW'(rp_ff);
   assign p_x      = AW'(p_ff);
   assign csr_size = (round4(AW'(csr_wdata)) > CAP) ? CAP : round4(AW'(csr_wdata));

   assign dp_status.rx_go     = (req_kind_type'(req_type) == REQ_RECEIVE) && !open_ff && !empty;
   assign dp_status.out_free  = out_free;
   assign dp_status.last_byte = (cnt_ff <= LEN_W'(1));
   assign dp_status.zero_len  = (cnt_ff == '0);

   // next values of the ring state and the result register
   always_comb begin
      size_in  = size_ff;
      free_in  = free_ff;
      max_in   = max_ff;
      rem_in   = rem_ff;
      head_in  = head_ff;
      wp_in    = wp_ff;
      rp_in    = rp_ff;
      p_in     = p_ff;
      open_in  = open_ff;
      cnt_in   = cnt_ff;
      rxlen_in = rxlen_ff;
      rv_in    = rv_ff && !rsp_ready;
      rst_in   = rst_ff;
      rbyte_in = rbyte_ff;
      rlen_in  = rlen_ff;
      rlast_in = rlast_ff;
      rfree_in = rfree_ff;
      rnext_in = rnext_ff;
      mem_we    = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = req_data_byte;
      rd_en     = 1'b0;
      rd_addr   = rp_ff;
      st        = ST_IGNORED;
      step_x    = ((wp_x + AW'(1)) >= size_ff) ? '0 : wp_x + AW'(1);
      algn_x    = (round4(step_x) >= size_ff) ? '0 : round4(step_x);
      p0_x      = ((rp_x + HDR) >= size_ff) ? '0 : rp_x + HDR;
      nrp_x     = ((p0_x + r4_head) >= size_ff) ? p0_x + r4_head - size_ff : p0_x + r4_head;
      free_add  = free_ff + HDR + r4_head;

      // configuration writes
      if (csr_we) begin
         if (csr_index == CSR_BUFFER_SIZE) begin
            size_in = csr_size;
            free_in = csr_size;
            wp_in   = '0;
            rp_in   = '0;
            rem_in  = '0;
            open_in = 1'b0;
         end else if (csr_index == CSR_MAX_MSG) begin
            max_in = csr_wdata[LEN_W-1:0];
         end
      end

      // single-result beats
      if (cmd.simple_load) begin
         case (req_kind_type'(req_type))
            REQ_SEND_BEGIN: begin
               if (open_ff) begin
                  st = ST_BUSY;
               end else if (req_msg_len == '0 || req_msg_len > lim) begin
                  st = ST_BAD_LEN;
               end else if (HDR + AW'(req_msg_len) > free_ff) begin
                  st = ST_NO_ROOM;
               end else begin
                  st        = ST_OK;
                  free_in   = free_ff - HDR - r4_len;
                  mem_we    = 1'b1;
                  mem_wdata = BYTE_W'(req_msg_len);
                  wp_in     = ((wp_x + HDR) >= size_ff) ? '0 : PTR_W'(wp_x + HDR);
                  rem_in    = req_msg_len;
                  open_in   = 1'b1;
                  if (empty) head_in = req_msg_len;
               end
            end
            REQ_SEND_DATA: begin
               if (open_ff) begin
                  st     = ST_OK;
                  mem_we = 1'b1;
                  rem_in = rem_ff - LEN_W'(1);
                  if (rem_ff == LEN_W'(1)) begin
                     wp_in   = PTR_W'(algn_x);
                     open_in = 1'b0;
                  end else begin
                     wp_in = PTR_W'(step_x);
                  end
               end
            end
            REQ_RECEIVE: begin
               st = open_ff ? ST_BUSY : ST_EMPTY;
            end
            default: st = ST_IGNORED;
         endcase
         rv_in    = 1'b1;
         rst_in   = st;
         rbyte_in = '0;
         rlen_in  = '0;
         rlast_in = 1'b1;
         rfree_in = SIZE_W'(free_in);
         rnext_in = (free_in == size_ff) ? '0 : head_in;
      end

      // start of a receive run: release the whole message
      if (cmd.rx_start) begin
         free_in  = (free_add > size_ff) ? size_ff : free_add;
         rp_in    = PTR_W'(nrp_x);
         p_in     = PTR_W'(p0_x);
         cnt_in   = head_ff;
         rxlen_in = head_ff;
      end

      // fetch the header of the new oldest message
      if (cmd.hdr_read) begin
         rd_en   = 1'b1;
         rd_addr = rp_ff;
      end
      if (cmd.hdr_load) begin
         head_in = (rdata_ff > BYTE_W'(MAX_MSG_BYTES)) ? MAX_LEN : rdata_ff[LEN_W-1:0];
      end

      // one message byte
      if (cmd.byte_read) begin
         rd_en   = 1'b1;
         rd_addr = p_ff;
         p_in    = ((p_x + AW'(1)) >= size_ff) ? '0 : PTR_W'(p_x + AW'(1));
      end
      if (cmd.byte_emit) begin
         rv_in    = 1'b1;
         rst_in   = ST_OK;
         rbyte_in = (cnt_ff == '0) ? '0 : rdata_ff;
         rlen_in  = rxlen_ff;
         rlast_in = (cnt_ff <= LEN_W'(1));
         rfree_in = SIZE_W'(free_ff);
         rnext_in = empty ? '0 : head_ff;
         cnt_in   = (cnt_ff == '0) ? '0 : cnt_ff - LEN_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= RESET_SIZE;
         free_ff <= RESET_SIZE;
         max_ff  <= LEN_W'(DEF_MAX_MSG_BYTES);
         rem_ff  <= '0;
         wp_ff   <= '0;
         rp_ff   <= '0;
         open_ff <= 1'b0;
         rv_ff   <= 1'b0;
      end else begin
         size_ff <= size_in;
         free_ff <= free_in;
         max_ff  <= max_in;
         rem_ff  <= rem_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         open_ff <= open_in;
         rv_ff   <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      p_ff     <= p_in;
      cnt_ff   <= cnt_in;
      rxlen_ff <= rxlen_in;
      rst_ff   <= rst_in;
      rbyte_ff <= rbyte_in;
      rlen_ff  <= rlen_in;
      rlast_ff <= rlast_in;
      rfree_ff <= rfree_in;
      rnext_ff <= rnext_in;
   end

   // byte store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = rst_ff;
   assign rsp_out_byte   = rbyte_ff;
   assign rsp_out_len    = rlen_ff;
   assign rsp_last       = rlast_ff;
   assign rsp_free_bytes = rfree_ff;
   assign rsp_next_len   = rnext_ff;

   // checks
   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      free_ff <= size_ff) else $error("free count above ring size");
   a_open_has_bytes: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> rem_ff != '0) else $error("open send with no bytes left");
   a_midrun_ok: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rlast_ff) |-> rst_ff == ST_OK) else $error("run beat without ok status");
   a_run_idle_send: assert property (@(posedge clock) disable iff (reset)
      cmd.rx_start |=> !open_ff) else $error("receive run with a send open");

endmodule

### rtl/variable_length_message_ring.sv
// Variable-length message ring. Send-begin reserves a 4-byte header plus the
// length rounded up to 4 and writes the length header; each send-data beat stores one
// byte; a receive releases the oldest message and returns it byte by byte with last on
// the final byte. Every beat other than an ok receive gives one result. An ok receive
// runs through the accepting state, a header read and a header load that fetch the
// header of the next oldest message, then per byte a registered read of the byte store
// and a result state that waits for a free result register. A new request is taken
// only when the result register is empty or its beat leaves in the same cycle.
// Writing buffer_size empties the ring at once; there is no clearing pass.
// depends on vlmr_pkg, vlmr_ctrl and vlmr_datapath
`timescale 1ns / 1ps

module variable_length_message_ring #(
   parameter int STORE_BYTES   = vlmr_pkg::DEF_STORE_BYTES,
   parameter int MAX_MSG_BYTES = vlmr_pkg::DEF_MAX_MSG_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [vlmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vlmr_pkg::SIZE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [vlmr_pkg::TYPE_W-1:0]    req_type,
   input  logic [vlmr_pkg::LEN_W-1:0]     req_msg_len,
   input  logic [vlmr_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vlmr_pkg::STAT_W-1:0]    rsp_status,
   output logic [vlmr_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [vlmr_pkg::LEN_W-1:0]     rsp_out_len,
   output logic                           rsp_last,
   output logic [vlmr_pkg::SIZE_W-1:0]    rsp_free_bytes,
   output logic [vlmr_pkg::LEN_W-1:0]     rsp_next_len
);
   import vlmr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // sequencer
   vlmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // ring datapath
   vlmr_datapath #(
      .STORE_BYTES   (STORE_BYTES),
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_msg_len    (req_msg_len),
      .req_data_byte  (req_data_byte),
      .cmd            (cmd),
      .dp_status      (dp_status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_len    (rsp_out_len),
      .rsp_last       (rsp_last),
      .rsp_free_bytes (rsp_free_bytes),
      .rsp_next_len   (rsp_next_len)
   );

endmodule

### tb/tb_variable_length_message_ring.sv
// tb_variable_length_message_ring: self-checking bench for the message ring, with
// directed and random beats checked against a behavioural ring predictor
// depends on vlmr_pkg and variable_length_message_ring
`timescale 1ns / 1ps

module tb_variable_length_message_ring;
   import vlmr_pkg::*;

   localparam int RING_BYTES  = DEF_STORE_BYTES;
   localparam int LEN_CAP     = DEF_MAX_MSG_BYTES;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [BYTE_W-1:0] out_byte;
      logic [LEN_W-1:0]  out_len;
      logic              last;
      logic [SIZE_W-1:0] free_bytes;
      logic [LEN_W-1:0]  next_len;
   } rsp_beat_type;

   typedef struct {
      req_kind_type      kind;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] data;
      bit                typed;
      status_type        st;
      int                free;
   } dir_row_type;

   logic                 clock, reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SIZE_W-1:0]    csr_wdata;
   logic                 req_valid, req_ready;
   logic [TYPE_W-1:0]    req_type;
   logic [LEN_W-1:0]     req_msg_len;
   logic [BYTE_W-1:0]    req_data_byte;
   logic                 rsp_valid, rsp_ready;
   logic [STAT_W-1:0]    rsp_status;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic [LEN_W-1:0]     rsp_out_len;
   logic                 rsp_last;
   logic [SIZE_W-1:0]    rsp_free_bytes;
   logic [LEN_W-1:0]     rsp_next_len;

   // predictor state
   logic [7:0]   ring_mem [RING_BYTES];
   int           ring_size, len_limit, rd_ptr, wr_ptr, free_cnt, send_left;
   bit           send_busy;
   rsp_beat_type pending_rsp [$];

   bit         failed;
   bit         gap_on;
   bit         row_typed;
   status_type row_st;
   int         row_free;
   int         stall_cnt;

   variable_length_message_ring dut (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int ring_next_len();
      int n;
      n = ring_mem[rd_ptr];
      if (free_cnt == ring_size) return 0;
      return n > LEN_CAP ? LEN_CAP : n;
   endfunction

   function automatic void push_rsp(status_type st, int b, int len, bit lst);
      rsp_beat_type r;
      r.status     = st;
      r.out_byte   = BYTE_W'(b);
      r.out_len    = LEN_W'(len);
      r.last       = lst;
      r.free_bytes = SIZE_W'(free_cnt);
      r.next_len   = LEN_W'(ring_next_len());
      pending_rsp.push_back(r);
   endfunction

   function automatic void ring_clear();
      rd_ptr    = 0;
      wr_ptr    = 0;
      free_cnt  = ring_size;
      send_left = 0;
      send_busy = 0;
   endfunction

   // ring predictor: updates the state and queues the expected beats of one request
   function automatic void ring_predict(logic [1:0] kind, int len, logic [7:0] db);
      int       lim, n, p;
      logic [7:0] msg_bytes [LEN_CAP];
      lim = len_limit < LEN_CAP ? len_limit : LEN_CAP;
      case (kind)
         REQ_SEND_BEGIN: begin
            if (send_busy) push_rsp(ST_BUSY, 0, 0, 1);
            else if (len == 0 || len > lim) push_rsp(ST_BAD_LEN, 0, 0, 1);
            else if (HEADER_BYTES + len > free_cnt) push_rsp(ST_NO_ROOM, 0, 0, 1);
            else begin
               free_cnt -= HEADER_BYTES + ((len + 3) & ~3);
               ring_mem[wr_ptr] = 8'(len);
               for (int i = 1; i < HEADER_BYTES; i++) ring_mem[wr_ptr + i] = 8'h00;
               wr_ptr += HEADER_BYTES;
               if (wr_ptr >= ring_size) wr_ptr = 0;
               send_left = len;
               send_busy = 1;
               push_rsp(ST_OK, 0, 0, 1);
            end
         end
         REQ_SEND_DATA: begin
            if (!send_busy) push_rsp(ST_IGNORED, 0, 0, 1);
            else begin
               ring_mem[wr_ptr] = db;
               wr_ptr = (wr_ptr + 1 >= ring_size) ? 0 : wr_ptr + 1;
               send_left--;
               if (send_left == 0) begin
                  wr_ptr = (wr_ptr + 3) & ~3;
                  if (wr_ptr >= ring_size) wr_ptr = 0;
                  send_busy = 0;
               end
               push_rsp(ST_OK, 0, 0, 1);
            end
         end
         REQ_RECEIVE: begin
            if (send_busy) push_rsp(ST_BUSY, 0, 0, 1);
            else if (free_cnt == ring_size) push_rsp(ST_EMPTY, 0, 0, 1);
            else begin
               n = ring_mem[rd_ptr];
               if (n > LEN_CAP) n = LEN_CAP;
               p = rd_ptr + HEADER_BYTES;
               if (p >= ring_size) p = 0;
               free_cnt += HEADER_BYTES + ((n + 3) & ~3);
               if (free_cnt > ring_size) free_cnt = ring_size;
               for (int i = 0; i < n; i++) begin
                  msg_bytes[i] = ring_mem[p];
                  p = (p + 1 >= ring_size) ? 0 : p + 1;
               end
               p = (p + 3) & ~3;
               rd_ptr = (p >= ring_size) ? 0 : p;
               // a zero-length header cannot be stored, kept for completeness
               if (n == 0) push_rsp(ST_OK, 0, 0, 1);
               for (int i = 0; i < n; i++) push_rsp(ST_OK, msg_bytes[i], n, i + 1 == n);
            end
         end
         default: push_rsp(ST_IGNORED, 0, 0, 1);
      endcase
   endfunction

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         failed = 1;
      end
   endtask

   // accept monitor, result checker and stall watchdog
   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            ring_predict(req_type, req_msg_len, req_data_byte);
            if (row_typed) begin
               e = pending_rsp[$];
               e.status     = row_st;
               e.free_bytes = SIZE_W'(row_free);
               pending_rsp[$] = e;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat with no expectation waiting");
               failed = 1;
            end else begin
               e = pending_rsp.pop_front();
               check_field("status", e.status, rsp_status);
               check_field("out_byte", e.out_byte, rsp_out_byte);
               check_field("out_len", e.out_len, rsp_out_len);
               check_field("last", e.last, rsp_last);
               check_field("free_bytes", e.free_bytes, rsp_free_bytes);
               check_field("next_len", e.next_len, rsp_next_len);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cnt = 0;
         else stall_cnt++;
         if (stall_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_ready <= !gap_on || ($urandom_range(0, 99) >= 24);
   end

   // one request beat, held until taken
   task automatic send_req(logic [1:0] kind, int len, logic [7:0] db);
      while (gap_on && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_msg_len   <= LEN_W'(len);
      req_data_byte <= db;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // register write, only once the ring has drained
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BUFFER_SIZE) begin
         ring_size = ((value & 11'h7FF) + 3) & ~3;
         if (ring_size > RING_BYTES) ring_size = RING_BYTES;
         ring_clear();
      end else len_limit = value & 7'h7F;
   endtask

   // random traffic: mostly whole messages and receives, the rest noise
   task automatic random_traffic(int n_items);
      int count, r, len, lim;
      count = 0;
      while (count < n_items) begin
         r   = $urandom_range(0, 99);
         lim = len_limit < LEN_CAP ? len_limit : LEN_CAP;
         if (lim < 1) lim = 1;
         if (r < 45) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, lim)
                                              : $urandom_range(1, lim < 8 ? lim : 8);
            if ($urandom_range(0, 19) == 0) len = lim;
            send_req(REQ_SEND_BEGIN, len, 8'($urandom));
            count++;
            for (int i = 0; i < len; i++) begin
               send_req(REQ_SEND_DATA, $urandom_range(0, 127), 8'($urandom_range(0, 255)));
               count++;
            end
         end else if (r < 75) begin
            send_req(REQ_RECEIVE, $urandom_range(0, 127), 8'($urandom));
            count++;
         end else begin
            send_req(2'($urandom_range(0, 3)), $urandom_range(0, 127),
                     8'($urandom_range(0, 255)));
            count++;
         end
      end
   endtask

   // stimulus
   initial begin
      dir_row_type dir_rows [$];
      failed        = 0;
      gap_on        = 1;
      row_typed     = 0;
      row_st        = ST_OK;
      row_free      = 0;
      stall_cnt     = 0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_BUFFER_SIZE;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_type      = REQ_SEND_BEGIN;
      req_msg_len   = '0;
      req_data_byte = '0;
      rsp_ready     = 1'b0;
      ring_size     = RING_BYTES;
      len_limit     = LEN_CAP;
      ring_clear();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed beats after reset
      dir_rows = '{
         '{REQ_RECEIVE,    0,   8'h00, 1, ST_EMPTY,   1024},
         '{REQ_SEND_DATA,  0,   8'hFF, 1, ST_IGNORED, 1024},
         '{REQ_UNUSED,     127, 8'hFF, 1, ST_IGNORED, 1024},
         '{REQ_SEND_BEGIN, 0,   8'h00, 1, ST_BAD_LEN, 1024},
         '{REQ_SEND_BEGIN, 65,  8'h00, 1, ST_BAD_LEN, 1024},
         '{REQ_SEND_BEGIN, 127, 8'h00, 1, ST_BAD_LEN, 1024},
         '{REQ_SEND_BEGIN, 1,   8'h00, 1, ST_OK,      1016},
         '{REQ_SEND_BEGIN, 5,   8'h00, 1, ST_BUSY,    1016},
         '{REQ_RECEIVE,    0,   8'h00, 1, ST_BUSY,    1016},
         '{REQ_SEND_DATA,  0,   8'h00, 1, ST_OK,      1016},
         '{REQ_SEND_BEGIN, 3,   8'h00, 1, ST_OK,      1008},
         '{REQ_SEND_DATA,  0,   8'hA5, 0, ST_OK,      0},
         '{REQ_SEND_DATA,  0,   8'h5A, 0, ST_OK,      0},
         '{REQ_SEND_DATA,  0,   8'hFF, 0, ST_OK,      0},
         '{REQ_SEND_BEGIN, 64,  8'h00, 1, ST_OK,      940},
         '{REQ_RECEIVE,    0,   8'h00, 1, ST_BUSY,    940},
         '{REQ_SEND_DATA,  0,   8'h11, 0, ST_OK,      0},
         '{REQ_RECEIVE,    0,   8'h00, 0, ST_OK,      0},
         '{REQ_RECEIVE,    0,   8'h00, 0, ST_OK,      0},
         '{REQ_RECEIVE,    0,   8'h00, 0, ST_OK,      0},
         '{REQ_RECEIVE,    0,   8'h00, 1, ST_EMPTY,   1024}
      };
      foreach (dir_rows[i]) begin
         row_typed = dir_rows[i].typed;
         row_st    = dir_rows[i].st;
         row_free  = dir_rows[i].free;
         send_req(dir_rows[i].kind, dir_rows[i].len, dir_rows[i].data);
         // fill the long message before the receives
         if (i == 16) begin
            row_typed = 0;
            for (int k = 1; k < 64; k++) send_req(REQ_SEND_DATA, 0, 8'(k * 4));
         end
      end
      row_typed = 0;

      // register settings, extremes included
      write_csr(CSR_BUFFER_SIZE, 16);
      random_traffic(50);
      write_csr(CSR_MAX_MSG, 1);
      write_csr(CSR_BUFFER_SIZE, 2047);
      random_traffic(40);
      write_csr(CSR_MAX_MSG, 127);
      write_csr(CSR_BUFFER_SIZE, 0);
      random_traffic(15);
      write_csr(CSR_MAX_MSG, 20);
      write_csr(CSR_BUFFER_SIZE, 5);
      random_traffic(40);
      write_csr(CSR_MAX_MSG, 64);
      write_csr(CSR_BUFFER_SIZE, 100);
      random_traffic(60);
      // long stretch with no idling on either side
      gap_on = 0;
      write_csr(CSR_BUFFER_SIZE, 1024);
      random_traffic(50);
      gap_on = 1;
      write_csr(CSR_MAX_MSG, 0);
      random_traffic(15);
      write_csr(CSR_MAX_MSG, 64);
      random_traffic(30);

      // drain
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (failed) $display("Simulation FAILED");
      else $display("Simulation PASSED");
      $finish;
   end

endmodule
